### rtl/core/rmsp_pkg.sv
// Shared types, codes and helpers for the ROI mask square painter.
// No dependencies.
`default_nettype none

package rmsp_pkg;

  localparam int FRAC_BITS = 8;
  localparam int COORD_W   = 15;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_PAINT = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_HALF   = 2'd2;

  localparam logic [10:0] WIDTH_RST  = 11'd1024;
  localparam logic [10:0] HEIGHT_RST = 11'd1024;
  localparam logic [5:0]  HALF_RST   = 6'd15;

  // center + disp / 256, rounded half away from zero
  function automatic coord_t round_pos(input logic [9:0] center,
                                       input logic signed [16:0] disp);
    logic signed [19:0] s;
    logic [19:0] mag;
    logic [19:0] q;
    s   = $signed({2'b00, center, 8'b0}) + $signed({{3{disp[16]}}, disp});
    mag = s[19] ? 20'(-s) : 20'(s);
    q   = (mag + 20'd128) >> FRAC_BITS;
    return s[19] ? -coord_t'(q) : coord_t'(q);
  endfunction

endpackage

`default_nettype wire

### rtl/core/roi_mask_square_painter_unit.sv
// ROI mask square painter: one-bit-per-pixel mask with clear, paint and read.
// Depends on rmsp_pkg and rmsp_ram.
//
// Usage: drive kind and its fields with start while busy is low; that beat
// is taken at the clock edge. Each beat yields exactly one result: done is
// high for one cycle with mask_word and painted valid; the receiver cannot
// stall, so the result must be taken in that cycle.
// Configuration (image_width, image_height, half_size) is to be written through
// cfg_write / cfg_index / cfg_data while busy is low and no result pends; the
// block itself does not enforce this.
// Per kind:
//   read  : one registered memory read.
//   paint : flags not both set: nothing painted; else clip (S_BOUNDS), empty check (S_BASE),
//           then a read-modify-write of each mask word through the single memory port pair.
//   clear : MAX_HEIGHT * ceil(MAX_WIDTH / 64) words, one word a cycle.
//   unused kind: done with no change.
// Back-to-back: busy is low while the result is on the ports, so the next beat
// can be taken at the edge that takes the result.
// Reset: control and config registers take their reset values; the mask memory
// is swept to zero, MAX_HEIGHT * ceil(MAX_WIDTH / 64) words, with busy high, no result.
`default_nettype none

module roi_mask_square_painter_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_HALF   = 63
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         kind,
  input  wire logic [9:0]         center_x,
  input  wire logic [9:0]         center_y,
  input  wire logic signed [16:0] disp_x,
  input  wire logic signed [16:0] disp_y,
  input  wire logic               converged,
  input  wire logic               above_threshold,
  input  wire logic [13:0]        word_address,
  output logic                    done,
  output logic [63:0]             mask_word,
  output logic                    painted,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [10:0]        cfg_data
);

  import rmsp_pkg::*;

  localparam int WORDS_PER_ROW = (MAX_WIDTH + 63) / 64;
  localparam int STORE_DEPTH   = MAX_HEIGHT * WORDS_PER_ROW;
  localparam int AW            = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CIW           = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_BOUNDS,
    S_BASE,
    S_RMW_RD,
    S_RMW_WR
  } state_t;

  state_t         state;
  logic [10:0]    image_width;
  logic [10:0]    image_height;
  logic [5:0]     half_size;
  logic [AW-1:0]  clr_addr;
  logic           clr_reply;
  logic           rd_oor;
  coord_t         cx;
  coord_t         cy;
  coord_t         x0;
  coord_t         x1;
  coord_t         y;
  coord_t         y1;
  logic [AW-1:0]  row_base;
  logic [CIW-1:0] wi;
  logic [CIW-1:0] wlo;
  logic [CIW-1:0] whi;

  coord_t         w_eff;
  coord_t         h_eff;
  coord_t         r_eff;
  coord_t         x0_next;
  coord_t         x1_next;
  coord_t         y0_next;
  coord_t         y1_next;
  logic [5:0]     bit_lo;
  logic [5:0]     bit_hi;
  logic [63:0]    bit_mask;
  logic [AW-1:0]  rmw_addr;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [63:0]    ram_wdata;
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [63:0]    ram_rdata;

  assign busy = (state != S_IDLE);

  always_comb begin
    w_eff = (int'(image_width) > MAX_WIDTH) ? coord_t'(MAX_WIDTH) : coord_t'(image_width);
    h_eff = (int'(image_height) > MAX_HEIGHT) ? coord_t'(MAX_HEIGHT)
                                              : coord_t'(image_height);
    r_eff = (int'(half_size) > MAX_HALF) ? coord_t'(MAX_HALF) : coord_t'(half_size);
    x0_next = cx - r_eff;
    x1_next = cx + r_eff;
    y0_next = cy - r_eff;
    y1_next = cy + r_eff;
    if (x0_next < 0) begin
      x0_next = '0;
    end
    if (y0_next < 0) begin
      y0_next = '0;
    end
    if (x1_next > w_eff - coord_t'(1)) begin
      x1_next = w_eff - coord_t'(1);
    end
    if (y1_next > h_eff - coord_t'(1)) begin
      y1_next = h_eff - coord_t'(1);
    end
  end

  always_comb begin
    bit_lo   = (wi == wlo) ? x0[5:0] : 6'd0;
    bit_hi   = (wi == whi) ? x1[5:0] : 6'd63;
    bit_mask = (64'hFFFF_FFFF_FFFF_FFFF << bit_lo)
             & (64'hFFFF_FFFF_FFFF_FFFF >> (6'd63 - bit_hi));
    rmw_addr = row_base + AW'(wi);
  end

  always_comb begin
    ram_we    = (state == S_CLEAR) || (state == S_RMW_WR);
    ram_waddr = (state == S_CLEAR) ? clr_addr : rmw_addr;
    ram_wdata = (state == S_CLEAR) ? 64'd0 : (ram_rdata | bit_mask);
    ram_re    = ((state == S_IDLE) && start && (kind == KIND_READ))
             || (state == S_RMW_RD);
    ram_raddr = (state == S_IDLE) ? AW'(word_address) : rmw_addr;
  end

  rmsp_ram #(
    .WIDTH(64),
    .DEPTH(STORE_DEPTH),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      clr_reply    <= 1'b0;
      done         <= 1'b0;
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
      half_size    <= HALF_RST;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_WIDTH:  image_width  <= cfg_data;
          CFG_HEIGHT: image_height <= cfg_data;
          CFG_HALF:   half_size    <= cfg_data[5:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            mask_word <= 64'd0;
            painted   <= 1'b0;
            unique case (kind)
              KIND_CLEAR: begin
                clr_addr  <= '0;
                clr_reply <= 1'b1;
                state     <= S_CLEAR;
              end
              KIND_PAINT: begin
                if (converged && above_threshold) begin
                  cx    <= round_pos(center_x, disp_x);
                  cy    <= round_pos(center_y, disp_y);
                  state <= S_BOUNDS;
                end else begin
                  done <= 1'b1;
                end
              end
              KIND_READ: begin
                rd_oor <= !(int'(word_address) < STORE_DEPTH);
                state  <= S_READ;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_CLEAR: begin
          if (clr_addr == AW'(STORE_DEPTH - 1)) begin
            done  <= clr_reply;
            state <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        S_READ: begin
          mask_word <= rd_oor ? 64'd0 : ram_rdata;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        S_BOUNDS: begin
          x0    <= x0_next;
          x1    <= x1_next;
          y     <= y0_next;
          y1    <= y1_next;
          state <= S_BASE;
        end
        S_BASE: begin
          if ((x0 > x1) || (y > y1)) begin
            painted <= 1'b1;
            done    <= 1'b1;
            state   <= S_IDLE;
          end else begin
            row_base <= AW'(int'(y) * WORDS_PER_ROW);
            wlo      <= x0[6 +: CIW];
            whi      <= x1[6 +: CIW];
            wi       <= x0[6 +: CIW];
            state    <= S_RMW_RD;
          end
        end
        S_RMW_RD: begin
          state <= S_RMW_WR;
        end
        S_RMW_WR: begin
          if (wi == whi) begin
            if (y == y1) begin
              painted <= 1'b1;
              done    <= 1'b1;
              state   <= S_IDLE;
            end else begin
              y        <= y + coord_t'(1);
              row_base <= row_base + AW'(WORDS_PER_ROW);
              wi       <= wlo;
              state    <= S_RMW_RD;
            end
          end else begin
            wi    <= wi + CIW'(1);
            state <= S_RMW_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/rmsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rmsp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
